[rtl/mnt_pkg.sv]
// ----------------------------------------------------------------------------
// mnt_pkg
// Types and constants shared by the mesh node table unit and its parts.
// ----------------------------------------------------------------------------
package mnt_pkg;

  localparam int IDX_W = 5;

  localparam logic [7:0] BATTERY_MAX     = 8'd100;
  localparam logic [7:0] BATTERY_UNKNOWN = 8'hFF;

  typedef enum logic [2:0] {
    ACT_TOUCH      = 3'd0,
    ACT_BATTERY    = 3'd1,
    ACT_FORGET     = 3'd2,
    ACT_READ       = 3'd3,
    ACT_TAKE_DIRTY = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_MISS,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    action_t            action;
    logic [31:0]        node_id;
    logic signed [7:0]  signal_strength;
    logic signed [3:0]  channel_in;
    logic [2:0]         hops_in;
    logic [31:0]        now_ms;
    logic [7:0]         battery_in;
    logic [4:0]         entry_index;
  } cmd_t;

  typedef struct packed {
    logic               hit;
    logic [4:0]         entry_count;
    logic               dirty_out;
    logic [31:0]        out_id;
    logic signed [7:0]  out_strength;
    logic [31:0]        out_time;
    logic signed [3:0]  out_channel;
    logic [2:0]         out_hops;
    logic signed [7:0]  out_battery;
  } res_t;

  typedef struct packed {
    logic [31:0]        node_id;
    logic signed [7:0]  strength;
    logic [31:0]        last_ms;
    logic signed [3:0]  channel;
    logic [2:0]         hops;
    logic signed [7:0]  battery;
  } entry_t;

  typedef struct packed {
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
  } ram_req_t;

endpackage

[rtl/mnt_ram.sv]
// ----------------------------------------------------------------------------
// mnt_ram
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mnt_ram #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  mnt_pkg::ram_req_t req,
  output mnt_pkg::entry_t   rd_data
);
  import mnt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr[AW-1:0]];
    end
  end

endmodule

[rtl/mesh_node_table_unit.sv]
// ----------------------------------------------------------------------------
// mesh_node_table_unit
// Table of heard mesh nodes keyed by id, with touch, set battery, forget,
// read by position and take-dirty operations, run by a small sequencer.
//
//   channel   handshake              payload
//   cmd       cmd_valid/cmd_ready    mnt_pkg::cmd_t
//   res       res_valid/res_ready    mnt_pkg::res_t
//
// one transaction at a time; the id search reads one entry per cycle from the
// entry store for touch, set battery and forget
// forget then moves each later entry down one place, read and then written back
// read at index reads the entry store only for an index below the entry count
// synchronous reset empties the table and clears the dirty flag
// a stalled result holds in the output register until taken
// ----------------------------------------------------------------------------
module mesh_node_table_unit #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  mnt_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output mnt_pkg::res_t res
);
  import mnt_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  state_t          state;
  state_t          state_next;
  cmd_t            op;
  logic [CW-1:0]   count;
  logic            dirty;
  logic [CW-1:0]   scan;
  logic [CW-1:0]   pend_idx;
  logic            pend_valid;
  logic [CW-1:0]   k;
  logic [CW-1:0]   k1;
  logic            hit;
  entry_t          rdf;
  entry_t          rd_data;
  ram_req_t        ram_req;
  logic            match;
  logic            idx_ok;
  logic            has_room;
  logic [7:0]      battery_clamped;

  assign match           = pend_valid && (rd_data.node_id == op.node_id);
  assign idx_ok          = 6'(cmd.entry_index) < 6'(count);
  assign has_room        = count < MAX_CNT;
  assign k1              = k + 1'b1;
  assign battery_clamped = (op.battery_in > BATTERY_MAX) ? BATTERY_MAX : op.battery_in;
  assign cmd_ready       = (state == ST_IDLE);

  mnt_ram #(.DEPTH(MAX_ENTRIES)) u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.action)
            ACT_TOUCH, ACT_BATTERY, ACT_FORGET: state_next = ST_SCAN;
            ACT_READ: state_next = idx_ok ? ST_READ : ST_DONE;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (match) begin
          state_next = ST_HIT;
        end else if (scan < count) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_MISS;
        end
      end
      ST_HIT: state_next = (op.action == ACT_FORGET) ? ST_SHIFT_RD : ST_DONE;
      ST_MISS: state_next = ST_DONE;
      ST_SHIFT_RD: state_next = (k1 < count) ? ST_SHIFT_WR : ST_DONE;
      ST_SHIFT_WR: state_next = ST_SHIFT_RD;
      ST_READ: state_next = ST_DONE;
      ST_DONE: begin
        if (!res_valid || res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // entry store control
  always_comb begin
    ram_req = '0;
    case (state)
      ST_IDLE: begin
        ram_req.rd_en   = cmd_valid && (cmd.action == ACT_READ) && idx_ok;
        ram_req.rd_addr = cmd.entry_index;
      end
      ST_SCAN: begin
        ram_req.rd_en   = !match && (scan < count);
        ram_req.rd_addr = IDX_W'(scan);
      end
      ST_HIT: begin
        ram_req.wr_en   = (op.action == ACT_TOUCH) || (op.action == ACT_BATTERY);
        ram_req.wr_addr = IDX_W'(pend_idx);
        ram_req.wr_data = rd_data;
        if (op.action == ACT_BATTERY) begin
          ram_req.wr_data.battery = battery_clamped;
        end else begin
          ram_req.wr_data.strength = op.signal_strength;
          ram_req.wr_data.last_ms  = op.now_ms;
          ram_req.wr_data.channel  = op.channel_in;
          ram_req.wr_data.hops     = op.hops_in;
        end
      end
      ST_MISS: begin
        ram_req.wr_en            = (op.action == ACT_TOUCH) && has_room;
        ram_req.wr_addr          = IDX_W'(count);
        ram_req.wr_data.node_id  = op.node_id;
        ram_req.wr_data.strength = op.signal_strength;
        ram_req.wr_data.last_ms  = op.now_ms;
        ram_req.wr_data.channel  = op.channel_in;
        ram_req.wr_data.hops     = op.hops_in;
        ram_req.wr_data.battery  = BATTERY_UNKNOWN;
      end
      ST_SHIFT_RD: begin
        ram_req.rd_en   = k1 < count;
        ram_req.rd_addr = IDX_W'(k1);
      end
      ST_SHIFT_WR: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = IDX_W'(k);
        ram_req.wr_data = rd_data;
      end
      default: ram_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      dirty     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_valid && res_ready && (state != ST_DONE)) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            op         <= cmd;
            scan       <= '0;
            pend_valid <= 1'b0;
            hit        <= 1'b0;
            rdf        <= '0;
          end
        end
        ST_SCAN: begin
          if (!match && (scan < count)) begin
            pend_valid <= 1'b1;
            pend_idx   <= scan;
            scan       <= scan + 1'b1;
          end
        end
        ST_HIT: begin
          hit <= 1'b1;
          k   <= pend_idx;
          if ((op.action == ACT_TOUCH) && (rd_data.channel != op.channel_in)) begin
            dirty <= 1'b1;
          end
        end
        ST_MISS: begin
          if ((op.action == ACT_TOUCH) && has_room) begin
            count <= count + 1'b1;
            dirty <= 1'b1;
            hit   <= 1'b1;
          end
        end
        ST_SHIFT_RD: begin
          if (!(k1 < count)) begin
            count <= count - 1'b1;
            dirty <= 1'b1;
          end
        end
        ST_SHIFT_WR: k <= k1;
        ST_READ: begin
          rdf <= rd_data;
          hit <= 1'b1;
        end
        ST_DONE: begin
          if (!res_valid || res_ready) begin
            res_valid        <= 1'b1;
            res.hit          <= hit;
            res.entry_count  <= 5'(count);
            res.dirty_out    <= dirty;
            res.out_id       <= rdf.node_id;
            res.out_strength <= rdf.strength;
            res.out_time     <= rdf.last_ms;
            res.out_channel  <= rdf.channel;
            res.out_hops     <= rdf.hops;
            res.out_battery  <= rdf.battery;
            if (op.action == ACT_TAKE_DIRTY) begin
              dirty <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/mnt_checker.sv]
// ----------------------------------------------------------------------------
// mnt_checker
// Port-level checks for the mesh node table unit, bound to the top level.
// ----------------------------------------------------------------------------
module mnt_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_ready,
  input mnt_pkg::cmd_t cmd,
  input logic          res_valid,
  input logic          res_ready,
  input mnt_pkg::res_t res
);
  import mnt_pkg::*;

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // one transaction in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while busy");

  // a new result marks the end of the work
  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> cmd_ready)
    else $error("result shown while still busy");

  // entry fields are zero on a result without a hit
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.hit |->
      res.out_id == 32'd0 && res.out_time == 32'd0 && res.out_battery == 8'sd0)
    else $error("entry fields set without a hit");

endmodule

bind mesh_node_table_unit mnt_checker u_mnt_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd       (cmd),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);
